// ===== sv/alw_pkg.sv =====
// shared constants, register codes and log table entry function for the waveshaper
`default_nettype none

package alw_pkg;

  localparam int SAMPLE_WIDTH_DEF   = 24;
  localparam int LOG_TABLE_BITS_DEF = 6;

  localparam int CFG_DATA_W  = 32;
  localparam int CFG_INDEX_W = 3;

  localparam int DRIVE_W = 24;
  localparam int GAIN_W  = 24;
  localparam int NORM_W  = 32;

  localparam int FRAC_W     = 32;
  localparam int TAB_W      = 25;
  localparam int LOG_FRAC_W = 24;
  localparam int SH_W       = 4;
  localparam int LOG_W      = SH_W + LOG_FRAC_W;
  // leading one of u sits within this many bits above its unit bit
  localparam int OCT_N      = 10;

  localparam int M1_SHIFT       = 21;
  localparam int M1_W           = NORM_W + LOG_W - M1_SHIFT;
  localparam int MAG_SHIFT_BASE = 40;

  localparam logic [DRIVE_W-1:0] DRIVE_RST = 24'h01_0000;
  localparam logic [GAIN_W-1:0]  GAIN_RST  = 24'h10_0000;
  localparam logic [NORM_W-1:0]  NORM_RST  = 32'h0001_0000;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_DRIVE_POS,
    REG_DRIVE_NEG,
    REG_GAIN_POS,
    REG_GAIN_NEG,
    REG_NORM_POS,
    REG_NORM_NEG,
    REG_BIAS_LEVEL,
    REG_INVERT_OUTPUT
  } reg_index_t;

  // log2(1 + i/2^bits) in Q0.24 by square-and-compare, last entry exactly 1.0
  function automatic logic [TAB_W-1:0] log_entry(input int unsigned i, input int unsigned bits);
    logic [63:0]      y;
    logic [TAB_W-1:0] res;
    res = '0;
    if (i == (32'd1 << bits)) begin
      res = TAB_W'(1) << LOG_FRAC_W;
    end else begin
      y = (64'd1 << 30) + (64'(i) << (30 - bits));
      for (int b = LOG_FRAC_W - 1; b >= 0; b--) begin
        y = (y * y) >> 30;
        if (y >= (64'd2 << 30)) begin
          y      = y >> 1;
          res[b] = 1'b1;
        end
      end
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== sv/alw_log2.sv =====
// pipelined log2 lookup: table read, linear interpolation, octave add
`default_nettype none

module alw_log2 #(
  parameter int LOG_TABLE_BITS = alw_pkg::LOG_TABLE_BITS_DEF,
  parameter int SIDE_W         = 1
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       up_valid,
  output logic                                       up_ready,
  input  logic [LOG_TABLE_BITS-1:0]                  idx,
  input  logic [alw_pkg::FRAC_W-LOG_TABLE_BITS-1:0]  rem,
  input  logic [alw_pkg::SH_W-1:0]                   sh,
  input  logic [SIDE_W-1:0]                          side,
  output logic                                       dn_valid,
  input  logic                                       dn_ready,
  output logic [alw_pkg::LOG_W-1:0]                  lg,
  output logic [SIDE_W-1:0]                          side_out
);
  import alw_pkg::*;

  localparam int RW    = FRAC_W - LOG_TABLE_BITS;
  localparam int TAB_N = (1 << LOG_TABLE_BITS) + 1;
  localparam int AW    = LOG_TABLE_BITS + 1;
  localparam int PRW   = TAB_W + RW;

  typedef logic [TAB_W-1:0] tab_t [TAB_N];

  function automatic tab_t build_tab();
    tab_t t;
    for (int i = 0; i < TAB_N; i++) begin
      t[i] = log_entry(i, LOG_TABLE_BITS);
    end
    return t;
  endfunction

  localparam tab_t LogTab = build_tab();

  logic v1, v2, v3;
  logic e1, e2, e3;

  logic [TAB_W-1:0]  lo1, hi1;
  logic [RW-1:0]     rem1;
  logic [SH_W-1:0]   sh1;
  logic [SIDE_W-1:0] side1;

  logic [TAB_W-1:0]  lo2, interp2;
  logic [SH_W-1:0]   sh2;
  logic [SIDE_W-1:0] side2;

  logic [LOG_W-1:0]  lg3;
  logic [SIDE_W-1:0] side3;

  logic [TAB_W-1:0]  span;
  logic [PRW-1:0]    prod;
  logic [AW-1:0]     addr;

  assign e3       = !v3 || dn_ready;
  assign e2       = !v2 || e3;
  assign e1       = !v1 || e2;
  assign up_ready = e1;
  assign dn_valid = v3;
  assign lg       = lg3;
  assign side_out = side3;

  assign addr = AW'(idx);
  assign span = hi1 - lo1;
  assign prod = PRW'(span) * PRW'(rem1);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (e1) v1 <= up_valid;
      if (e2) v2 <= v1;
      if (e3) v3 <= v2;
    end
  end

  // table read, both neighbors
  always_ff @(posedge clk) begin
    if (e1) begin
      lo1   <= LogTab[addr];
      hi1   <= LogTab[addr + AW'(1)];
      rem1  <= rem;
      sh1   <= sh;
      side1 <= side;
    end
  end

  // interpolation product
  always_ff @(posedge clk) begin
    if (e2) begin
      lo2     <= lo1;
      interp2 <= prod[PRW-1:RW];
      sh2     <= sh1;
      side2   <= side1;
    end
  end

  // octave plus mantissa log
  always_ff @(posedge clk) begin
    if (e3) begin
      lg3   <= {sh2, LOG_FRAC_W'(0)} + LOG_W'(lo2) + LOG_W'(interp2);
      side3 <= side2;
    end
  end

  a_tab_monotonic: assert property (@(posedge clk) disable iff (rst)
    v1 |-> hi1 >= lo1)
    else $error("log table neighbors out of order");

  a_interp_bounded: assert property (@(posedge clk) disable iff (rst)
    v2 |-> (LOG_W'(lo2) + LOG_W'(interp2)) <= (LOG_W'(1) << LOG_FRAC_W))
    else $error("interpolated mantissa log above one");

  a_log_range: assert property (@(posedge clk) disable iff (rst)
    v3 |-> lg3 < (LOG_W'(OCT_N) << LOG_FRAC_W))
    else $error("log result beyond octave range");

endmodule

`default_nettype wire

// ===== sv/asymmetric_log_waveshaper.sv =====
// top level of the asymmetric logarithmic waveshaper with its configuration registers
// pipeline: nine register stages, stages 1 to 3, the three log2 stages, then stages 4 to 6
// throughput: one sample per cycle while the output is not held back; each multiplier and the table read own a stage
// every stage holds under backpressure and empty stages keep taking input meanwhile
// reset: configuration registers return to their defaults and the pipeline empties at once
// the log table is a constant rom, so no fill pass follows reset
`default_nettype none

module asymmetric_log_waveshaper #(
  parameter int SAMPLE_WIDTH   = alw_pkg::SAMPLE_WIDTH_DEF,
  parameter int LOG_TABLE_BITS = alw_pkg::LOG_TABLE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [alw_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [alw_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                sample_in_valid,
  output logic                                sample_in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0]      sample_in,
  output logic                                sample_out_valid,
  input  logic                                sample_out_ready,
  output logic signed [SAMPLE_WIDTH-1:0]      sample_out
);
  import alw_pkg::*;

  localparam int S      = SAMPLE_WIDTH;
  localparam int FB     = 16 + S - 1;
  localparam int PW     = DRIVE_W + S;
  localparam int UW     = FB + OCT_N;
  localparam int WW     = UW + FRAC_W;
  localparam int RW     = FRAC_W - LOG_TABLE_BITS;
  localparam int SIDE_W = NORM_W + GAIN_W + 1;
  localparam int NLW    = NORM_W + LOG_W;
  localparam int M2_W   = M1_W + GAIN_W;
  localparam int MAG_W  = M2_W - (MAG_SHIFT_BASE - S);
  localparam logic [MAG_W-1:0] LimNeg = MAG_W'(1) << (S - 1);
  localparam logic [MAG_W-1:0] LimPos = LimNeg - MAG_W'(1);

  // configuration registers
  logic [DRIVE_W-1:0]        drive_pos, drive_neg;
  logic signed [GAIN_W-1:0]  gain_pos, gain_neg;
  logic [NORM_W-1:0]         norm_pos, norm_neg;
  logic signed [S-1:0]       bias_level;
  logic                      invert_output;

  always_ff @(posedge clk) begin
    if (rst) begin
      drive_pos     <= DRIVE_RST;
      drive_neg     <= DRIVE_RST;
      gain_pos      <= GAIN_RST;
      gain_neg      <= GAIN_RST;
      norm_pos      <= NORM_RST;
      norm_neg      <= NORM_RST;
      bias_level    <= '0;
      invert_output <= 1'b0;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_DRIVE_POS:     drive_pos     <= cfg_data[DRIVE_W-1:0];
        REG_DRIVE_NEG:     drive_neg     <= cfg_data[DRIVE_W-1:0];
        REG_GAIN_POS:      gain_pos      <= cfg_data[GAIN_W-1:0];
        REG_GAIN_NEG:      gain_neg      <= cfg_data[GAIN_W-1:0];
        REG_NORM_POS:      norm_pos      <= cfg_data[NORM_W-1:0];
        REG_NORM_NEG:      norm_neg      <= cfg_data[NORM_W-1:0];
        REG_BIAS_LEVEL:    bias_level    <= cfg_data[S-1:0];
        REG_INVERT_OUTPUT: invert_output <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // pipeline control
  logic v1, v2, v3, v4, v5, v6;
  logic en1, en2, en3, en4, en5, en6;
  logic log_up_ready, log_dn_valid;

  assign en6 = !v6 || sample_out_ready;
  assign en5 = !v5 || en6;
  assign en4 = !v4 || en5;
  assign en3 = !v3 || log_up_ready;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;

  assign sample_in_ready  = en1;
  assign sample_out_valid = v6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else begin
      if (en1) v1 <= sample_in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= log_dn_valid;
      if (en5) v5 <= v4;
      if (en6) v6 <= v5;
    end
  end

  // stage 1: side select and distance from bias
  logic signed [S:0]        diff;
  logic [S:0]               ndiff;
  logic                     pos;
  logic signed [GAIN_W-1:0] gain_sel;
  logic [GAIN_W-1:0]        ag_c;
  logic [S-1:0]             r1;
  logic [DRIVE_W-1:0]       drive1;
  logic [NORM_W-1:0]        norm1;
  logic [GAIN_W-1:0]        ag1;
  logic                     neg1;

  assign diff     = {sample_in[S-1], sample_in} - {bias_level[S-1], bias_level};
  assign ndiff    = -diff;
  assign pos      = !diff[S];
  assign gain_sel = pos ? gain_pos : gain_neg;
  assign ag_c     = gain_sel[GAIN_W-1] ? (~gain_sel) + GAIN_W'(1) : gain_sel;

  always_ff @(posedge clk) begin
    if (en1) begin
      r1     <= pos ? diff[S-1:0] : ndiff[S-1:0];
      drive1 <= pos ? drive_pos : drive_neg;
      norm1  <= pos ? norm_pos : norm_neg;
      ag1    <= ag_c;
      neg1   <= gain_sel[GAIN_W-1] ^ !pos ^ invert_output;
    end
  end

  // stage 2: drive times distance
  logic [PW-1:0]     p2;
  logic [NORM_W-1:0] norm2;
  logic [GAIN_W-1:0] ag2;
  logic              neg2;

  always_ff @(posedge clk) begin
    if (en2) begin
      p2    <= PW'(drive1) * PW'(r1);
      norm2 <= norm1;
      ag2   <= ag1;
      neg2  <= neg1;
    end
  end

  // stage 3: leading one and fraction of 1 + drive*r
  logic [UW-1:0]             u;
  logic [SH_W-1:0]           sh_c;
  logic [WW-1:0]             wide, shifted;
  logic [FRAC_W-1:0]         frac;
  logic [LOG_TABLE_BITS-1:0] idx3;
  logic [RW-1:0]             rem3;
  logic [SH_W-1:0]           sh3;
  logic [SIDE_W-1:0]         side3;

  assign u = UW'(p2) + (UW'(1) << FB);

  always_comb begin
    sh_c = '0;
    for (int j = 0; j < OCT_N; j++) begin
      if (u[FB + j]) sh_c = SH_W'(j);
    end
  end

  assign wide    = {u, FRAC_W'(0)};
  assign shifted = (wide >> FB) >> sh_c;
  assign frac    = shifted[FRAC_W-1:0];

  always_ff @(posedge clk) begin
    if (en3) begin
      idx3  <= frac[FRAC_W-1 -: LOG_TABLE_BITS];
      rem3  <= frac[RW-1:0];
      sh3   <= sh_c;
      side3 <= {norm2, ag2, neg2};
    end
  end

  // log2 stages
  logic [LOG_W-1:0]  lg_l;
  logic [SIDE_W-1:0] side_l;
  logic [NORM_W-1:0] norm_l;
  logic [GAIN_W-1:0] ag_l;
  logic              neg_l;

  alw_log2 #(
    .LOG_TABLE_BITS (LOG_TABLE_BITS),
    .SIDE_W         (SIDE_W)
  ) u_log2 (
    .clk      (clk),
    .rst      (rst),
    .up_valid (v3),
    .up_ready (log_up_ready),
    .idx      (idx3),
    .rem      (rem3),
    .sh       (sh3),
    .side     (side3),
    .dn_valid (log_dn_valid),
    .dn_ready (en4),
    .lg       (lg_l),
    .side_out (side_l)
  );

  assign {norm_l, ag_l, neg_l} = side_l;

  // stage 4: norm times log
  logic [NLW-1:0]    nl_prod;
  logic [M1_W-1:0]   m1_4;
  logic [GAIN_W-1:0] ag4;
  logic              neg4;

  assign nl_prod = NLW'(norm_l) * NLW'(lg_l);

  always_ff @(posedge clk) begin
    if (en4) begin
      m1_4 <= nl_prod[NLW-1:M1_SHIFT];
      ag4  <= ag_l;
      neg4 <= neg_l;
    end
  end

  // stage 5: gain magnitude
  logic [M2_W-1:0]  m2;
  logic [MAG_W-1:0] mag5;
  logic             neg5;

  assign m2 = M2_W'(m1_4) * M2_W'(ag4);

  always_ff @(posedge clk) begin
    if (en5) begin
      mag5 <= m2[M2_W-1:MAG_SHIFT_BASE-S];
      neg5 <= neg4;
    end
  end

  // stage 6: saturate and apply sign
  logic [MAG_W-1:0] sat_mag, neg_mag;
  logic [S-1:0]     out_c;

  always_comb begin
    if (neg5) begin
      sat_mag = (mag5 > LimNeg) ? LimNeg : mag5;
      neg_mag = MAG_W'(0) - sat_mag;
      out_c   = neg_mag[S-1:0];
    end else begin
      sat_mag = (mag5 > LimPos) ? LimPos : mag5;
      neg_mag = '0;
      out_c   = sat_mag[S-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en6) begin
      sample_out <= out_c;
    end
  end

  a_octave_range: assert property (@(posedge clk) disable iff (rst)
    v3 |-> sh3 < SH_W'(OCT_N))
    else $error("leading one beyond expected octave range");

  a_positive_sign: assert property (@(posedge clk) disable iff (rst)
    (v5 && !neg5 && en6) |=> !sample_out[S-1])
    else $error("positive result produced a negative sample");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (v5 && !en5) |=> (v5 && $stable(mag5) && $stable(neg5)))
    else $error("stalled magnitude stage changed");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !sample_out_valid)
    else $error("output valid after reset");

endmodule

`default_nettype wire

// ===== verif/asymmetric_log_waveshaper_checker.sv =====
// checker for the waveshaper: mirrors the registers, predicts and compares each transfer
module asymmetric_log_waveshaper_checker #(
  parameter int SAMPLE_WIDTH   = alw_pkg::SAMPLE_WIDTH_DEF,
  parameter int LOG_TABLE_BITS = alw_pkg::LOG_TABLE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [alw_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [alw_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             in_valid,
  input  logic                             in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0]   sample_in,
  input  logic                             out_valid,
  input  logic                             out_ready,
  input  logic signed [SAMPLE_WIDTH-1:0]   sample_out,
  output int                               fail_count,
  output int                               outstanding,
  output int                               results_checked
);
  timeunit 1ns;
  timeprecision 1ps;
  import alw_pkg::*;

  localparam int UNIT_POS = 16 + SAMPLE_WIDTH - 1;
  localparam int ENTRIES  = (1 << LOG_TABLE_BITS) + 1;
  localparam int SEG_BITS = 32 - LOG_TABLE_BITS;

  logic [63:0]                    log_rom [ENTRIES];
  logic [DRIVE_W-1:0]             drv_p, drv_n;
  logic signed [GAIN_W-1:0]       gn_p, gn_n;
  logic [NORM_W-1:0]              nrm_p, nrm_n;
  logic signed [SAMPLE_WIDTH-1:0] bias;
  logic                           inv;
  logic signed [SAMPLE_WIDTH-1:0] shaped_q [$];
  logic signed [SAMPLE_WIDTH-1:0] want;
  int                             samples_taken;
  int                             reported;

  // log2(1 + i/2^bits) in Q0.24, squaring a Q1.30 mantissa once per result bit
  function automatic logic [63:0] rom_entry(input int i);
    logic [63:0] y;
    logic [63:0] res;
    res = '0;
    if (i == ENTRIES - 1) begin
      res = 64'd1 << 24;
    end else begin
      y = (64'd1 << 30) + (64'(i) << (30 - LOG_TABLE_BITS));
      for (int b = 23; b >= 0; b--) begin
        y = (y * y) >> 30;
        if (y >= (64'd2 << 30)) begin
          y      = y >> 1;
          res[b] = 1'b1;
        end
      end
    end
    return res;
  endfunction

  initial begin
    for (int i = 0; i < ENTRIES; i++) log_rom[i] = rom_entry(i);
  end

  function automatic logic [63:0] log2_q24(input logic [63:0] u);
    int          k;
    int          idx;
    logic [63:0] t, frac, seg, lo, hi;
    k = 63;
    while (k > 0 && !u[k]) k--;
    t    = u - (64'd1 << k);
    frac = (k >= 32) ? (t >> (k - 32)) : (t << (32 - k));
    frac = frac & 64'hFFFF_FFFF;
    idx  = int'(frac >> SEG_BITS);
    seg  = frac & ((64'd1 << SEG_BITS) - 64'd1);
    lo   = log_rom[idx];
    hi   = log_rom[idx + 1];
    return (64'(k - UNIT_POS) << 24) + lo + (((hi - lo) * seg) >> SEG_BITS);
  endfunction

  function automatic logic signed [SAMPLE_WIDTH-1:0] shape(
    input logic signed [SAMPLE_WIDTH-1:0] x
  );
    logic signed [SAMPLE_WIDTH:0]   xe, be, diff;
    logic signed [63:0]             g;
    logic [63:0]                    r, drive, norm, ag, u, m1, mag, lim, word;
    logic                           pos, neg;
    pos   = (x >= bias);
    xe    = (SAMPLE_WIDTH+1)'(x);
    be    = (SAMPLE_WIDTH+1)'(bias);
    diff  = pos ? (xe - be) : (be - xe);
    r     = 64'(diff);
    drive = pos ? 64'(drv_p) : 64'(drv_n);
    norm  = pos ? 64'(nrm_p) : 64'(nrm_n);
    g     = pos ? 64'(gn_p) : 64'(gn_n);
    ag    = (g < 0) ? 64'(-g) : 64'(g);
    u     = drive * r + (64'd1 << UNIT_POS);
    m1    = (norm * log2_q24(u)) >> 21;
    mag   = (m1 * ag) >> (40 - SAMPLE_WIDTH);
    neg   = (g < 0) ^ !pos ^ inv;
    lim   = 64'd1 << (SAMPLE_WIDTH - 1);
    if (neg) begin
      if (mag > lim) mag = lim;
      word = 64'd0 - mag;
    end else begin
      if (mag > lim - 64'd1) mag = lim - 64'd1;
      word = mag;
    end
    return word[SAMPLE_WIDTH-1:0];
  endfunction

  assign outstanding = samples_taken - results_checked;

  always @(posedge clk) begin
    if (rst) begin
      drv_p = DRIVE_RST;
      drv_n = DRIVE_RST;
      gn_p  = GAIN_RST;
      gn_n  = GAIN_RST;
      nrm_p = NORM_RST;
      nrm_n = NORM_RST;
      bias  = '0;
      inv   = 1'b0;
      shaped_q.delete();
      samples_taken   <= 0;
      results_checked <= 0;
      fail_count      <= 0;
    end else begin
      // check before push so a result never meets a sample taken in the same cycle
      if (out_valid && out_ready) begin
        results_checked <= results_checked + 1;
        if (shaped_q.size() == 0) begin
          fail_count <= fail_count + 1;
          if (reported < 10)
            $display("%0t: sample_out %0d with no sample pending", $realtime, sample_out);
          reported++;
        end else begin
          want = shaped_q.pop_front();
          if (sample_out !== want) begin
            fail_count <= fail_count + 1;
            if (reported < 10)
              $display("%0t: sample_out mismatch, expected %0d got %0d",
                       $realtime, want, sample_out);
            reported++;
          end
        end
      end
      if (cfg_we) begin
        case (reg_index_t'(cfg_index))
          REG_DRIVE_POS:     drv_p = cfg_data[DRIVE_W-1:0];
          REG_DRIVE_NEG:     drv_n = cfg_data[DRIVE_W-1:0];
          REG_GAIN_POS:      gn_p  = cfg_data[GAIN_W-1:0];
          REG_GAIN_NEG:      gn_n  = cfg_data[GAIN_W-1:0];
          REG_NORM_POS:      nrm_p = cfg_data[NORM_W-1:0];
          REG_NORM_NEG:      nrm_n = cfg_data[NORM_W-1:0];
          REG_BIAS_LEVEL:    bias  = cfg_data[SAMPLE_WIDTH-1:0];
          REG_INVERT_OUTPUT: inv   = cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        shaped_q.push_back(shape(sample_in));
        samples_taken <= samples_taken + 1;
      end
    end
  end

endmodule

// ===== verif/asymmetric_log_waveshaper_tb.sv =====
// testbench top for the asymmetric log waveshaper: clock, reset, register settings, traffic and verdict
module asymmetric_log_waveshaper_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import alw_pkg::*;

  localparam int SW             = SAMPLE_WIDTH_DEF;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES    = 300;
  localparam int SETTLE_CYCLES  = 20;
  localparam int SET_ITEMS      = 85;

  typedef enum {TR_STEADY, TR_SRC_GAPS, TR_SINK_STALLS, TR_BOTH, TR_BACKPRESSURE} traffic_t;

  typedef struct {
    logic [DRIVE_W-1:0]       drive_pos;
    logic [DRIVE_W-1:0]       drive_neg;
    logic signed [GAIN_W-1:0] gain_pos;
    logic signed [GAIN_W-1:0] gain_neg;
    logic [NORM_W-1:0]        norm_pos;
    logic [NORM_W-1:0]        norm_neg;
    logic signed [SW-1:0]     bias;
    logic                     invert;
  } shaper_cfg_t;

  logic                   clk              = 1'b0;
  logic                   rst              = 1'b1;
  logic                   cfg_we           = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index        = '0;
  logic [CFG_DATA_W-1:0]  cfg_data         = '0;
  logic                   sample_in_valid  = 1'b0;
  logic                   sample_in_ready;
  logic signed [SW-1:0]   sample_in        = '0;
  logic                   sample_out_valid;
  logic                   sample_out_ready = 1'b0;
  logic signed [SW-1:0]   sample_out;

  traffic_t    traffic = TR_STEADY;
  shaper_cfg_t active;
  int          fail_count, outstanding, results_checked;
  int          items_sent;
  int          settings_loaded;
  int          quiet;

  localparam logic signed [SW-1:0] S_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] S_MIN = {1'b1, {(SW-1){1'b0}}};

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  asymmetric_log_waveshaper uut (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .sample_in_valid  (sample_in_valid),
    .sample_in_ready  (sample_in_ready),
    .sample_in        (sample_in),
    .sample_out_valid (sample_out_valid),
    .sample_out_ready (sample_out_ready),
    .sample_out       (sample_out)
  );

  asymmetric_log_waveshaper_checker chk (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (sample_in_valid),
    .in_ready        (sample_in_ready),
    .sample_in       (sample_in),
    .out_valid       (sample_out_valid),
    .out_ready       (sample_out_ready),
    .sample_out      (sample_out),
    .fail_count      (fail_count),
    .outstanding     (outstanding),
    .results_checked (results_checked)
  );

  // 1/log2(1 + alpha) in Q16.16, as software would load it
  function automatic logic [NORM_W-1:0] norm_for(input logic [DRIVE_W-1:0] drive);
    real a;
    a = drive / 65536.0;
    return $rtoi(65536.0 * $ln(2.0) / $ln(1.0 + a) + 0.5);
  endfunction

  function automatic logic [DRIVE_W-1:0] pick_drive();
    logic [DRIVE_W-1:0] d;
    d = DRIVE_W'($urandom);
    d = d >> $urandom_range(DRIVE_W - 1);
    if (d < DRIVE_W'(7)) d = DRIVE_W'(7);
    return d;
  endfunction

  function automatic logic signed [GAIN_W-1:0] pick_gain();
    logic signed [GAIN_W-1:0] g;
    g = GAIN_W'($urandom);
    case ($urandom_range(3))
      0: ;
      1: g = g >>> $urandom_range(GAIN_W - 1);
      2: g = g[GAIN_W-1] ? -24'sh10_0000 : 24'sh10_0000;
      default: g = g >>> 3;
    endcase
    return g;
  endfunction

  function automatic shaper_cfg_t random_cfg();
    shaper_cfg_t c;
    c.drive_pos = pick_drive();
    c.drive_neg = pick_drive();
    c.norm_pos  = ($urandom_range(9) == 0) ? NORM_W'($urandom) : norm_for(c.drive_pos);
    c.norm_neg  = ($urandom_range(9) == 0) ? NORM_W'($urandom) : norm_for(c.drive_neg);
    c.gain_pos  = pick_gain();
    c.gain_neg  = pick_gain();
    c.bias      = SW'($urandom);
    c.bias      = c.bias >>> $urandom_range(SW - 1);
    c.invert    = 1'($urandom_range(1));
    return c;
  endfunction

  function automatic shaper_cfg_t make_cfg(
    input logic [DRIVE_W-1:0] dp, input logic [DRIVE_W-1:0] dn,
    input logic signed [GAIN_W-1:0] gp, input logic signed [GAIN_W-1:0] gn,
    input logic [NORM_W-1:0] np, input logic [NORM_W-1:0] nn,
    input logic signed [SW-1:0] b, input logic inv
  );
    shaper_cfg_t c;
    c.drive_pos = dp;
    c.drive_neg = dn;
    c.gain_pos  = gp;
    c.gain_neg  = gn;
    c.norm_pos  = np;
    c.norm_neg  = nn;
    c.bias      = b;
    c.invert    = inv;
    return c;
  endfunction

  function automatic logic signed [SW-1:0] random_sample();
    logic signed [SW-1:0] d, x;
    d = SW'($urandom);
    d = d >>> $urandom_range(SW - 1);
    x = SW'($urandom);
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(3))
          0: x = S_MAX;
          1: x = S_MIN;
          2: x = active.bias;
          default: x = '0;
        endcase
      end
      1, 2, 3: x = active.bias + d;
      default: ;
    endcase
    return x;
  endfunction

  task automatic put_reg(input reg_index_t idx, input logic [CFG_DATA_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
  endtask

  task automatic load_cfg(input shaper_cfg_t c);
    put_reg(REG_DRIVE_POS, CFG_DATA_W'(c.drive_pos));
    put_reg(REG_DRIVE_NEG, CFG_DATA_W'(c.drive_neg));
    put_reg(REG_GAIN_POS, CFG_DATA_W'(c.gain_pos));
    put_reg(REG_GAIN_NEG, CFG_DATA_W'(c.gain_neg));
    put_reg(REG_NORM_POS, c.norm_pos);
    put_reg(REG_NORM_NEG, c.norm_neg);
    put_reg(REG_BIAS_LEVEL, CFG_DATA_W'(c.bias));
    put_reg(REG_INVERT_OUTPUT, CFG_DATA_W'(c.invert));
    cfg_we <= 1'b0;
    active = c;
    settings_loaded++;
  endtask

  task automatic send(input logic signed [SW-1:0] x);
    int idle;
    idle = (traffic == TR_SRC_GAPS) ? 77 : (traffic == TR_BOTH) ? 12 : 0;
    while ($urandom_range(99) < idle) begin
      sample_in_valid <= 1'b0;
      @(posedge clk);
    end
    sample_in_valid <= 1'b1;
    sample_in       <= x;
    @(posedge clk);
    while (!sample_in_ready) @(posedge clk);
    items_sent++;
  endtask

  // one edge first so the count includes the last transfer
  task automatic drain();
    sample_in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // output side: one long hold the first time backpressure traffic starts
  initial begin
    int hold_left;
    bit held;
    int stall;
    hold_left = 0;
    held      = 1'b0;
    forever begin
      @(posedge clk);
      if (traffic == TR_BACKPRESSURE && !held) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      stall = (traffic == TR_SINK_STALLS) ? 77 : (traffic == TR_BOTH) ? 12 : 0;
      if (hold_left > 0) begin
        hold_left--;
        sample_out_ready <= 1'b0;
      end else begin
        sample_out_ready <= ($urandom_range(99) >= stall);
      end
    end
  end

  always @(posedge clk) begin
    if ((sample_in_valid && sample_in_ready) || (sample_out_valid && sample_out_ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= WATCHDOG_LIMIT) begin
      $display("timeout: no transfer for %0d cycles, %0d samples pending", quiet, outstanding);
      $display("asymmetric_log_waveshaper_tb: FAIL");
      $finish;
    end
  end

  initial begin
    traffic_t modes [5];
    modes = '{TR_STEADY, TR_SRC_GAPS, TR_SINK_STALLS, TR_BOTH, TR_BACKPRESSURE};
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // reset values of every register
    send('0);
    send(S_MAX);
    send(S_MIN);
    send(24'sd1);
    send(-24'sd1);
    send(24'sh40_0000);
    drain();

    // saturation on both sides, largest and smallest drive, sample equal to bias
    load_cfg(make_cfg(24'hFF_FFFF, 24'd7, 24'sh7F_FFFF, 24'sh7F_FFFF,
                      32'hFFFF_FFFF, 32'hFFFF_FFFF, '0, 1'b0));
    send(S_MAX);
    send(S_MIN);
    send('0);
    send(24'sd1);
    drain();

    // zero drive, lowest bias, most negative gain
    load_cfg(make_cfg(24'd0, 24'd7, 24'sh80_0000, 24'sh10_0000,
                      NORM_RST, norm_for(24'd7), S_MIN, 1'b1));
    send(S_MIN);
    send(S_MAX);
    send('0);
    drain();

    // zero norm on one side, highest bias, inverted output
    load_cfg(make_cfg(24'hFF_FFFF, 24'hFF_FFFF, 24'sh80_0000, 24'sh80_0000,
                      32'd0, 32'hFFFF_FFFF, S_MAX, 1'b1));
    send(S_MAX);
    send(S_MIN);
    send('0);
    drain();

    foreach (modes[m]) begin
      traffic <= modes[m];
      for (int s = 0; s < 2; s++) begin
        load_cfg(random_cfg());
        for (int n = 0; n < SET_ITEMS; n++) send(random_sample());
        drain();
      end
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("%0d samples sent, %0d results compared, %0d register settings loaded",
             items_sent, results_checked, settings_loaded);
    $display("traffic: steady, sender gaps, receiver stalls, both, and a %0d-cycle output hold",
             HOLD_CYCLES);
    if (fail_count == 0)
      $display("asymmetric_log_waveshaper_tb: PASS");
    else
      $display("asymmetric_log_waveshaper_tb: FAIL");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/alw_pkg.sv
sv/alw_log2.sv
sv/asymmetric_log_waveshaper.sv
verif/asymmetric_log_waveshaper_checker.sv
verif/asymmetric_log_waveshaper_tb.sv
